>>> sv/otfr_pkg.sv
// otfr_pkg: shared constants, font tables and control/status types for the
// oled text framebuffer refresh block
// depends on nothing; used by every other file of the block but otfr_ram
package otfr_pkg;

    // display geometry
    localparam int COLUMNS     = 128;
    localparam int PAGES       = 8;
    localparam int FRAME_DEPTH = COLUMNS * PAGES;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int PAGE_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int PAGE_SPAN   = COLUMNS + 3;
    localparam int OFF_W       = $clog2(PAGE_SPAN);

    // text cursor and row widths
    localparam int CUR_W = 10;
    localparam int ROW_W = 8;
    localparam int CH_W  = 8;
    localparam int X_W   = 9;

    // draw sequencing: six columns, two pages each
    localparam int GLYPH_COLS   = 6;
    localparam int DRAW_STEPS   = GLYPH_COLS * 2;
    localparam int CHAR_ADVANCE = 6;

    // request kinds
    localparam logic [1:0] FN_CLEAR   = 2'd0;
    localparam logic [1:0] FN_BEGIN   = 2'd1;
    localparam logic [1:0] FN_CHAR    = 2'd2;
    localparam logic [1:0] FN_REFRESH = 2'd3;

    // refresh stream command bytes
    localparam logic [7:0] CMD_PAGE_BASE   = 8'hB0;
    localparam logic [7:0] CMD_COL_HI_BASE = 8'h10;
    localparam logic [3:0] NIBBLE_MASK     = 4'hF;
    localparam logic [6:0] COL_OFFSET_RST  = 7'd2;

    // stream offsets inside one page span
    localparam logic [OFF_W-1:0] OFF_PAGE_CMD = OFF_W'(0);
    localparam logic [OFF_W-1:0] OFF_COL_LO   = OFF_W'(1);
    localparam logic [OFF_W-1:0] OFF_COL_HI   = OFF_W'(2);
    localparam logic [OFF_W-1:0] OFF_DATA     = OFF_W'(3);
    localparam logic [OFF_W-1:0] OFF_LAST     = OFF_W'(PAGE_SPAN - 1);

    // 5x7 font
    localparam int GLYPH_COUNT = 22;
    localparam int GLYPH_W     = $clog2(GLYPH_COUNT);
    localparam logic [GLYPH_W-1:0] GLYPH_SPACE = GLYPH_W'(GLYPH_COUNT - 1);

    localparam logic [7:0] FONT_CODES [GLYPH_COUNT] = '{
        8'h41, 8'h43, 8'h45, 8'h47, 8'h49, 8'h4B, 8'h4E, 8'h4F, 8'h52, 8'h53, 8'h54,
        8'h55, 8'h57, 8'h65, 8'h67, 8'h72, 8'h73, 8'h74, 8'h75, 8'h3A, 8'h5F, 8'h20
    };

    localparam logic [7:0] FONT_ROWS [GLYPH_COUNT][5] = '{
        '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E},   // A
        '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22},   // C
        '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41},   // E
        '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A},   // G
        '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00},   // I
        '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41},   // K
        '{8'h7F, 8'h02, 8'h04, 8'h08, 8'h7F},   // N
        '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E},   // O
        '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},   // R
        '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31},   // S
        '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},   // T
        '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F},   // U
        '{8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F},   // W
        '{8'h38, 8'h54, 8'h54, 8'h54, 8'h18},   // e
        '{8'h18, 8'hA4, 8'hA4, 8'hA4, 8'h7C},   // g
        '{8'h7C, 8'h08, 8'h04, 8'h04, 8'h08},   // r
        '{8'h48, 8'h54, 8'h54, 8'h54, 8'h24},   // s
        '{8'h04, 8'h3F, 8'h44, 8'h40, 8'h20},   // t
        '{8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C},   // u
        '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00},   // colon
        '{8'h40, 8'h40, 8'h40, 8'h40, 8'h40},   // underscore
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}    // space
    };

    // unknown codes fall back to space
    function automatic logic [GLYPH_W-1:0] font_index(input logic [CH_W-1:0] code);
        logic [GLYPH_W-1:0] idx;
        idx = GLYPH_SPACE;
        for (int i = GLYPH_COUNT - 1; i >= 0; i--)
        begin
            if (FONT_CODES[i] == code)
            begin
                idx = GLYPH_W'(i);
            end
        end
        return idx;
    endfunction

    // sixth column is the blank spacer
    function automatic logic [7:0] glyph_column(input logic [GLYPH_W-1:0] g,
                                                input logic [2:0] col);
        logic [7:0] bits;
        bits = 8'h00;
        if (col < 3'd5)
        begin
            bits = FONT_ROWS[g][col];
        end
        return bits;
    endfunction

    // controller to datapath commands
    typedef struct packed {
        logic load_str;
        logic load_char;
        logic cnt_clr;
        logic clr_wr;
        logic draw_rd;
        logic draw_wr;
        logic cur_adv;
        logic ref_rd;
        logic ref_load;
    } ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic draw_ok;
        logic cnt_last_clr;
        logic cnt_last_draw;
        logic out_free;
    } sts_t;

endpackage

>>> sv/otfr_ram.sv
// otfr_ram: generic single write port, single read port ram with registered read
// no dependencies
module otfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/otfr_ctrl.sv
// otfr_ctrl: request sequencer for clear sweep, character draw and refresh pull
// depends on otfr_pkg (ctl_t, sts_t, request kinds)
module otfr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [1:0]      func,
    input  otfr_pkg::sts_t  sts,
    output otfr_pkg::ctl_t  ctl
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DRAW,
        ST_DRAW_END,
        ST_REF_WAIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   accept;

    assign accept   = s_tvalid && ready_reg;
    assign s_tready = ready_reg;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        otfr_pkg::FN_CLEAR:
                        begin
                            ctl.cnt_clr = 1'b1;
                            state_next  = ST_CLEAR;
                        end
                        otfr_pkg::FN_BEGIN:
                        begin
                            ctl.load_str = 1'b1;
                        end
                        otfr_pkg::FN_CHAR:
                        begin
                            ctl.load_char = 1'b1;
                            ctl.cnt_clr   = 1'b1;
                            if (sts.draw_ok)
                            begin
                                state_next = ST_DRAW;
                            end
                            else
                            begin
                                ctl.cur_adv = 1'b1;
                            end
                        end
                        otfr_pkg::FN_REFRESH:
                        begin
                            ctl.ref_rd = 1'b1;
                            state_next = ST_REF_WAIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                ctl.clr_wr = 1'b1;
                if (sts.cnt_last_clr)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DRAW:
            begin
                ctl.draw_rd = 1'b1;
                ctl.draw_wr = 1'b1;
                if (sts.cnt_last_draw)
                begin
                    state_next = ST_DRAW_END;
                end
            end
            ST_DRAW_END:
            begin
                ctl.draw_wr = 1'b1;
                ctl.cur_adv = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_REF_WAIT:
            begin
                if (sts.out_free)
                begin
                    ctl.ref_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

`ifndef SYNTHESIS
    a_clear_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && sts.cnt_last_clr) |=> (state_reg == ST_IDLE && s_tready))
        else $error("clear sweep did not return to idle");

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ref_load |-> sts.out_free)
        else $error("refresh byte loaded over a pending output");

    a_draw_twelve: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAW && sts.cnt_last_draw) |=> state_reg == ST_DRAW_END)
        else $error("draw burst did not close after last step");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.clr_wr || ctl.draw_rd || ctl.ref_load) |-> !s_tready)
        else $error("request taken while a sequence was running");
`endif

endmodule

>>> sv/otfr_dpath.sv
// otfr_dpath: cursor, draw address/merge logic, refresh stream counters, output register
// depends on otfr_pkg and otfr_ram (framebuffer storage)
module otfr_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  otfr_pkg::ctl_t              ctl,
    output otfr_pkg::sts_t              sts,
    input  logic [otfr_pkg::X_W-1:0]    in_x,
    input  logic [otfr_pkg::ROW_W-1:0]  in_y,
    input  logic [otfr_pkg::CH_W-1:0]   in_ch,
    input  logic                        cfg_we,
    input  logic [6:0]                  cfg_data,
    input  logic                        out_take,
    output logic                        out_valid,
    output logic [7:0]                  out_byte,
    output logic                        out_is_data,
    output logic                        out_start,
    output logic [2:0]                  out_page,
    output logic                        out_last
);

    localparam int AW = otfr_pkg::ADDR_W;
    localparam int CW = otfr_pkg::CUR_W;
    localparam int RW = otfr_pkg::ROW_W;
    localparam int PW = otfr_pkg::PAGE_W;
    localparam int OW = otfr_pkg::OFF_W;

    // text state
    logic [CW-1:0]                    cursor_reg;
    logic [RW-1:0]                    row_reg;
    logic [otfr_pkg::GLYPH_W-1:0]     glyph_reg;
    logic [6:0]                       col_offset_reg;
    logic [AW-1:0]                    cnt_reg;

    // pending write of the draw read-modify-write
    logic                             pend_valid_reg;
    logic [AW-1:0]                    pend_addr_reg;
    logic [7:0]                       pend_bits_reg;
    logic [7:0]                       pend_mask_reg;

    // refresh stream position
    logic [PW-1:0]                    pg_reg;
    logic [OW-1:0]                    off_reg;

    // output register
    logic                             out_valid_reg;
    logic [7:0]                       out_byte_reg;
    logic                             out_is_data_reg;
    logic                             out_start_reg;
    logic [2:0]                       out_page_reg;
    logic                             out_last_reg;

    // draw step decode
    logic [2:0]                       step_col;
    logic                             step_hi;
    logic [CW:0]                      step_px;
    logic                             col_ok;
    logic [RW-2:0]                    step_page;
    logic                             page_ok;
    logic [15:0]                      wide_bits;
    logic [15:0]                      wide_mask;
    logic [7:0]                       step_bits;
    logic [7:0]                       step_mask;
    logic                             step_valid;
    logic [AW-1:0]                    step_addr;

    logic [CW:0]                      cur_adv;
    logic [CW-1:0]                    cur_adv_sat;
    logic [AW-1:0]                    ref_addr;
    logic [7:0]                       rd_data;

    logic                             ram_we;
    logic [AW-1:0]                    ram_waddr;
    logic [7:0]                       ram_wdata;
    logic                             ram_re;
    logic [AW-1:0]                    ram_raddr;

    logic [7:0]                       ref_byte;
    logic                             ref_is_data;
    logic                             ref_start;
    logic                             ref_last;

    // step k covers glyph column k/2, upper or lower page of the glyph
    assign step_col = cnt_reg[3:1];
    assign step_hi  = cnt_reg[0];
    assign step_px  = {cursor_reg[CW-1], cursor_reg} + (CW+1)'(step_col);
    assign col_ok   = !step_px[CW] && (step_px[CW-1:0] < CW'(otfr_pkg::COLUMNS));

    assign step_page = {{2{row_reg[RW-1]}}, row_reg[RW-1:3]} + (RW-1)'(step_hi);
    assign page_ok   = !step_page[RW-2]
                       && (step_page[RW-3:0] < (RW-2)'(otfr_pkg::PAGES));

    assign wide_bits = {8'h00, otfr_pkg::glyph_column(glyph_reg, step_col)} << row_reg[2:0];
    assign wide_mask = 16'h00FF << row_reg[2:0];
    assign step_bits = step_hi ? wide_bits[15:8] : wide_bits[7:0];
    assign step_mask = step_hi ? wide_mask[15:8] : wide_mask[7:0];

    assign step_valid = col_ok && page_ok && (step_mask != 8'h00);
    assign step_addr  = step_valid
                        ? (AW'(step_page[RW-3:0]) * AW'(otfr_pkg::COLUMNS) + AW'(step_px))
                        : '0;

    // cursor advance saturates at the right edge
    assign cur_adv     = {cursor_reg[CW-1], cursor_reg} + (CW+1)'(otfr_pkg::CHAR_ADVANCE);
    assign cur_adv_sat = (!cur_adv[CW] && (cur_adv[CW-1:0] > CW'(otfr_pkg::COLUMNS)))
                         ? CW'(otfr_pkg::COLUMNS) : cur_adv[CW-1:0];

    assign ref_addr = AW'(pg_reg) * AW'(otfr_pkg::COLUMNS)
                      + AW'(off_reg - otfr_pkg::OFF_DATA);

    // framebuffer port muxing
    assign ram_we    = ctl.clr_wr || (ctl.draw_wr && pend_valid_reg);
    assign ram_waddr = ctl.clr_wr ? cnt_reg : pend_addr_reg;
    assign ram_wdata = ctl.clr_wr ? 8'h00
                       : ((rd_data & ~pend_mask_reg) | (pend_bits_reg & pend_mask_reg));
    assign ram_re    = ctl.draw_rd || ctl.ref_rd;
    assign ram_raddr = ctl.ref_rd ? ((off_reg >= otfr_pkg::OFF_DATA) ? ref_addr : '0)
                                  : step_addr;

    otfr_ram #(
        .WIDTH (8),
        .DEPTH (otfr_pkg::FRAME_DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    // refresh byte selection
    always_comb
    begin
        ref_is_data = 1'b0;
        ref_start   = 1'b1;
        ref_last    = 1'b0;
        if (off_reg == otfr_pkg::OFF_PAGE_CMD)
        begin
            ref_byte = otfr_pkg::CMD_PAGE_BASE + 8'(pg_reg);
        end
        else if (off_reg == otfr_pkg::OFF_COL_LO)
        begin
            ref_byte = {4'h0, col_offset_reg[3:0] & otfr_pkg::NIBBLE_MASK};
        end
        else if (off_reg == otfr_pkg::OFF_COL_HI)
        begin
            ref_byte = otfr_pkg::CMD_COL_HI_BASE + 8'(col_offset_reg[6:4]);
        end
        else
        begin
            ref_byte    = rd_data;
            ref_is_data = 1'b1;
            ref_start   = (off_reg == otfr_pkg::OFF_DATA);
            ref_last    = (pg_reg == PW'(otfr_pkg::PAGES - 1))
                          && (off_reg == otfr_pkg::OFF_LAST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg     <= '0;
            row_reg        <= '0;
            col_offset_reg <= otfr_pkg::COL_OFFSET_RST;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pg_reg         <= '0;
            off_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                col_offset_reg <= cfg_data;
            end
            if (ctl.load_str)
            begin
                cursor_reg <= {in_x[otfr_pkg::X_W-1], in_x};
                row_reg    <= in_y;
            end
            else if (ctl.cur_adv)
            begin
                cursor_reg <= cur_adv_sat;
            end
            if (ctl.cnt_clr)
            begin
                cnt_reg        <= '0;
                pend_valid_reg <= 1'b0;
            end
            else if (ctl.clr_wr || ctl.draw_rd)
            begin
                cnt_reg <= cnt_reg + AW'(1);
            end
            if (ctl.draw_rd)
            begin
                pend_valid_reg <= step_valid;
            end
            if (ctl.ref_load)
            begin
                if (off_reg == otfr_pkg::OFF_LAST)
                begin
                    off_reg <= '0;
                    pg_reg  <= (pg_reg == PW'(otfr_pkg::PAGES - 1)) ? '0 : pg_reg + PW'(1);
                end
                else
                begin
                    off_reg <= off_reg + OW'(1);
                end
            end
            if (ctl.ref_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_char)
        begin
            glyph_reg <= otfr_pkg::font_index(in_ch);
        end
        if (ctl.draw_rd)
        begin
            pend_addr_reg <= step_addr;
            pend_bits_reg <= step_bits;
            pend_mask_reg <= step_mask;
        end
        if (ctl.ref_load)
        begin
            out_byte_reg    <= ref_byte;
            out_is_data_reg <= ref_is_data;
            out_start_reg   <= ref_start;
            out_page_reg    <= 3'(pg_reg);
            out_last_reg    <= ref_last;
        end
    end

    assign sts.draw_ok       = cursor_reg[CW-1]
                               || (cursor_reg[CW-2:0]
                                   <= (CW-1)'(otfr_pkg::COLUMNS - otfr_pkg::CHAR_ADVANCE));
    assign sts.cnt_last_clr  = (cnt_reg == AW'(otfr_pkg::FRAME_DEPTH - 1));
    assign sts.cnt_last_draw = (cnt_reg == AW'(otfr_pkg::DRAW_STEPS - 1));
    assign sts.out_free      = !out_valid_reg || out_take;

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign out_is_data = out_is_data_reg;
    assign out_start   = out_start_reg;
    assign out_page    = out_page_reg;
    assign out_last    = out_last_reg;

endmodule

>>> sv/oled_text_framebuffer_refresh.sv
// oled_text_framebuffer_refresh: top level of the page-organized text framebuffer
// depends on otfr_pkg, otfr_ctrl, otfr_dpath (which holds otfr_ram)
//
// channel   dir  handshake                  contents
// s_*       in   s_tvalid / s_tready        request: kind in tuser, x/y/ch in tdata
// m_*       out  m_tvalid / m_tready        refresh stream byte with tags
// cfg_*     in   cfg_valid / cfg_ready      column_offset register write
//
// sequencing: begin string and a skipped character finish at acceptance; a drawn character
//   runs accept, 12 read-modify-write steps of one ram read and write port, and a
//   closing write; a refresh byte runs accept with its ram read, then waits for the output slot
// clear and reset both run a zeroing sweep over all COLUMNS*PAGES bytes (1024 here),
//   one framebuffer byte per cycle; no request is taken during the sweep
// a waiting output byte holds the next refresh request inside the block, and every
//   request behind that one waits too; requests ahead of it proceed
// cfg_ready is always high; writes are meant to land while the block is idle
module oled_text_framebuffer_refresh (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,    // [1:0] func
    input  logic [31:0] s_tdata,    // [8:0] x, [16:9] y, [24:17] ch, [31:25] zero

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] byte_value, [8] starts_transfer, [11:9] page
    output logic        m_tuser,    // [0] is_data
    output logic        m_tlast,    // last_of_frame

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    otfr_pkg::ctl_t ctl;
    otfr_pkg::sts_t sts;

    logic       out_valid;
    logic [7:0] out_byte;
    logic       out_is_data;
    logic       out_start;
    logic [2:0] out_page;
    logic       out_last;

    // config is always taken
    assign cfg_ready = 1'b1;

    otfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .func     (s_tuser),
        .sts      (sts),
        .ctl      (ctl)
    );

    otfr_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .in_x        (s_tdata[8:0]),
        .in_y        (s_tdata[16:9]),
        .in_ch       (s_tdata[24:17]),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .out_take    (m_tvalid && m_tready),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .out_is_data (out_is_data),
        .out_start   (out_start),
        .out_page    (out_page),
        .out_last    (out_last)
    );

    // pack the output stream word
    assign m_tvalid = out_valid;
    assign m_tdata  = {4'h0, out_page, out_start, out_byte};
    assign m_tuser  = out_is_data;
    assign m_tlast  = out_last;

endmodule
